/* rtl/lmd_pkg.sv */
`timescale 1ns / 1ps
package lmd_pkg;

  // Field widths of the words on both channels
  localparam int PIXEL_W = 8;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 5;
  localparam int COUNT_W = 11;
  localparam int SUM_W   = 18;
  localparam int MEAN_W  = 16;
  localparam int FRAC_W  = 8;

  // Mean divider: (sum << FRAC_W) / count
  localparam int DIVIDEND_W = SUM_W + FRAC_W;

  // Configuration registers
  localparam int SIZE_W    = 6;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_NUM_ROWS = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_NUM_COLS = 1'd1;
  localparam logic [SIZE_W-1:0]    NUM_ROWS_RST = 6'd32;
  localparam logic [SIZE_W-1:0]    NUM_COLS_RST = 6'd32;

  // Default frame limits
  localparam int MAX_ROWS_DEF = 32;
  localparam int MAX_COLS_DEF = 32;

  // Result word kinds
  localparam logic KIND_REPORT  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

endpackage

/* rtl/lmd_ifs.sv */
`timescale 1ns / 1ps
interface lmd_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [lmd_pkg::PIXEL_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface lmd_result_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [lmd_pkg::PIXEL_W-1:0] value;
  logic [lmd_pkg::ROW_W-1:0]   row;
  logic [lmd_pkg::COL_W-1:0]   col;
  logic [lmd_pkg::COUNT_W-1:0] max_count;
  logic [lmd_pkg::SUM_W-1:0]   max_sum;
  logic [lmd_pkg::MEAN_W-1:0]  mean_q8;
  logic                        none_found;
  logic                        last;

  modport source (output valid, output kind, output value, output row, output col,
                  output max_count, output max_sum, output mean_q8, output none_found,
                  output last, input ready);
  modport sink   (input valid, input kind, input value, input row, input col,
                  input max_count, input max_sum, input mean_q8, input none_found,
                  input last, output ready);
endinterface

/* rtl/local_maximum_detector_core.sv */
`timescale 1ns / 1ps
// Reports: a maximum report is registered in S_EVAL, after the pixel below it is taken
// and the S_RC, S_RL and S_RR reads. A row-0 pixel is only stored; any other is accepted,
// read three times and evaluated, and a report that waits for the output register holds it.
// Input: a new pixel is taken only once the last one is done. Frame end: a sweep of the last
// row, column by column, then the mean divider (skipped with no maximum) before the summary.
// Reset: synchronous, active high; counters clear, sizes go to 32.
module local_maximum_detector_core #(
  parameter int MAX_ROWS = lmd_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = lmd_pkg::MAX_COLS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [lmd_pkg::REG_IDX_W-1:0]    wr_index,
  input  logic [lmd_pkg::SIZE_W-1:0]       wr_data,
  lmd_pixel_if.sink                        pix,
  lmd_result_if.source                     res
);

  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RSW = RW + 1;
  localparam int CSW = CW + 1;
  localparam int PW  = lmd_pkg::PIXEL_W;

  typedef struct packed {
    logic                        kind;
    logic [PW-1:0]               value;
    logic [lmd_pkg::ROW_W-1:0]   row;
    logic [lmd_pkg::COL_W-1:0]   col;
    logic [lmd_pkg::COUNT_W-1:0] max_count;
    logic [lmd_pkg::SUM_W-1:0]   max_sum;
    logic [lmd_pkg::MEAN_W-1:0]  mean_q8;
    logic                        none_found;
    logic                        last;
  } result_t;

  // Judge sequence: read center+up, read left, read right, evaluate.
  // The sweep of the last row reuses it with the line stores' roles swapped.
  typedef enum logic [2:0] {
    S_IDLE, S_RC, S_RL, S_RR, S_EVAL, S_DIVGO, S_DIV, S_SUM
  } state_t;

  state_t state;

  // Configuration registers and clamped sizes
  logic [lmd_pkg::SIZE_W-1:0] num_rows;
  logic [lmd_pkg::SIZE_W-1:0] num_cols;
  logic [RSW-1:0]             rows_eff;
  logic [CSW-1:0]             cols_eff;

  // Frame position and accumulators
  logic [RW-1:0]               row_count;
  logic [CW-1:0]               col_count;
  logic [lmd_pkg::SUM_W-1:0]   sum_acc;
  logic [lmd_pkg::COUNT_W-1:0] count_acc;
  logic                        sel;       // bank holding the row above

  // Item being worked on
  logic [PW-1:0] pix_q;
  logic [RW-1:0] row_q;
  logic [CW-1:0] idx;
  logic          last_col_q;
  logic          last_row_q;
  logic          judge_en;
  logic          flush;

  // Judge operands
  logic [PW-1:0] center;
  logic [PW-1:0] up;
  logic [PW-1:0] left;
  logic [PW-1:0] right;

  // Position of the incoming pixel, clamped to the current size
  logic [RW-1:0] row_in;
  logic [CW-1:0] col_in;

  // Line store access
  logic [CW-1:0] rd_addr;
  logic [PW-1:0] rd_data0;
  logic [PW-1:0] rd_data1;
  logic [PW-1:0] ctr_rd;
  logic [PW-1:0] up_rd;
  logic          ram_wr;

  // Evaluation
  logic up_ok;
  logic dn_ok;
  logic lf_ok;
  logic rt_ok;
  logic last_idx;
  logic is_max;
  logic out_free;
  logic eval_go;
  logic out_load;

  // Output register
  logic    out_valid;
  result_t out_word;

  // Mean divider
  logic                           div_start;
  logic                           div_done;
  logic [lmd_pkg::DIVIDEND_W-1:0] div_quot;
  logic [lmd_pkg::MEAN_W-1:0]     mean_q;

  // A size of zero acts as one; a size above the limit acts as the limit
  always_comb begin
    if (num_rows == '0) begin
      rows_eff = RSW'(1);
    end else if (int'(num_rows) > MAX_ROWS) begin
      rows_eff = RSW'(MAX_ROWS);
    end else begin
      rows_eff = RSW'(num_rows);
    end
    if (num_cols == '0) begin
      cols_eff = CSW'(1);
    end else if (int'(num_cols) > MAX_COLS) begin
      cols_eff = CSW'(MAX_COLS);
    end else begin
      cols_eff = CSW'(num_cols);
    end
  end

  // A counter at or past the size acts as the last row or column
  always_comb begin
    row_in = ({1'b0, row_count} < rows_eff) ? row_count : RW'(rows_eff - 1'b1);
    col_in = ({1'b0, col_count} < cols_eff) ? col_count : CW'(cols_eff - 1'b1);
  end

  // Neighbor existence and the strict-greater test
  always_comb begin
    up_ok    = flush ? (row_q != '0) : (row_q > RW'(1));
    dn_ok    = !flush;
    lf_ok    = (idx != '0);
    rt_ok    = (({1'b0, idx} + 1'b1) < cols_eff);
    last_idx = (({1'b0, idx} + 1'b1) == cols_eff);
    is_max   = judge_en
               && (!up_ok || center > up)
               && (!dn_ok || center > pix_q)
               && (!lf_ok || center > left)
               && (!rt_ok || center > ctr_rd);
    out_free = !out_valid || res.ready;
    // Hold in evaluation while a report waits for the output register
    eval_go  = !(is_max && !out_free);
    // A new word enters the output register this cycle
    out_load = ((state == S_EVAL) && is_max && out_free)
               || ((state == S_SUM) && out_free);
  end

  // Center bank is the row above for a pixel, the current row for the sweep.
  // Both banks share one read address; only the center bank's data matters past S_RL.
  always_comb begin
    ctr_rd = (sel ^ flush) ? rd_data1 : rd_data0;
    up_rd  = (sel ^ flush) ? rd_data0 : rd_data1;
    unique case (state)
      S_RC:         rd_addr = idx;
      S_RL:         rd_addr = lf_ok ? idx - 1'b1 : idx;
      S_RR, S_EVAL: rd_addr = rt_ok ? idx + 1'b1 : idx;
      default:      rd_addr = idx;
    endcase
    // Store the pixel into the current row once it has been judged against
    ram_wr = (state == S_EVAL) && !flush && eval_go;
  end

  lmd_ram #(.WIDTH(PW), .DEPTH(MAX_COLS)) u_bank0 (
    .clk   (clk),
    .we    (ram_wr && sel),
    .waddr (idx),
    .wdata (pix_q),
    .raddr (rd_addr),
    .rdata (rd_data0)
  );

  lmd_ram #(.WIDTH(PW), .DEPTH(MAX_COLS)) u_bank1 (
    .clk   (clk),
    .we    (ram_wr && !sel),
    .waddr (idx),
    .wdata (pix_q),
    .raddr (rd_addr),
    .rdata (rd_data1)
  );

  assign div_start = (state == S_DIVGO) && (count_acc != '0);

  lmd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({sum_acc, lmd_pkg::FRAC_W'(0)}),
    .divisor  (count_acc),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= lmd_pkg::NUM_ROWS_RST;
      num_cols <= lmd_pkg::NUM_COLS_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        lmd_pkg::REG_NUM_ROWS: num_rows <= wr_data;
        lmd_pkg::REG_NUM_COLS: num_cols <= wr_data;
      endcase
    end
  end

  // Sequencer, frame counters, accumulators and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      row_count <= '0;
      col_count <= '0;
      sum_acc   <= '0;
      count_acc <= '0;
      sel       <= 1'b0;
      flush     <= 1'b0;
      judge_en  <= 1'b0;
    end else begin
      // Drop the output word once taken, unless a new word loads below
      if (out_valid && res.ready && !out_load) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (pix.valid) begin
            pix_q      <= pix.pixel;
            row_q      <= row_in;
            idx        <= col_in;
            last_col_q <= ({1'b0, col_in} == cols_eff - 1'b1);
            last_row_q <= ({1'b0, row_in} == rows_eff - 1'b1);
            flush      <= 1'b0;
            judge_en   <= (row_in != '0);
            // Row 0 has nothing above to judge: just store the pixel
            state      <= (row_in != '0) ? S_RC : S_EVAL;
          end
        end

        S_RC: state <= S_RL;

        S_RL: begin
          center <= ctr_rd;
          up     <= up_rd;
          state  <= S_RR;
        end

        S_RR: begin
          left  <= ctr_rd;
          state <= S_EVAL;
        end

        S_EVAL: begin
          if (eval_go) begin
            if (is_max) begin
              out_valid           <= 1'b1;
              out_word.kind       <= lmd_pkg::KIND_REPORT;
              out_word.value      <= center;
              out_word.row        <= flush ? lmd_pkg::ROW_W'(row_q)
                                           : lmd_pkg::ROW_W'(row_q - 1'b1);
              out_word.col        <= lmd_pkg::COL_W'(idx);
              out_word.max_count  <= '0;
              out_word.max_sum    <= '0;
              out_word.mean_q8    <= '0;
              out_word.none_found <= 1'b0;
              // Last word of this pixel unless the frame-end sweep follows
              out_word.last       <= !flush && !(last_col_q && last_row_q);
              sum_acc             <= sum_acc + lmd_pkg::SUM_W'(center);
              count_acc           <= count_acc + 1'b1;
            end
            if (!flush) begin
              if (last_col_q && last_row_q) begin
                // Frame end: sweep the last row from column 0
                flush    <= 1'b1;
                judge_en <= 1'b1;
                idx      <= '0;
                state    <= S_RC;
              end else if (last_col_q) begin
                // Row end: the current row becomes the row above
                row_count <= row_q + 1'b1;
                col_count <= '0;
                sel       <= !sel;
                state     <= S_IDLE;
              end else begin
                row_count <= row_q;
                col_count <= idx + 1'b1;
                state     <= S_IDLE;
              end
            end else if (last_idx) begin
              state <= S_DIVGO;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_RC;
            end
          end
        end

        S_DIVGO: begin
          if (count_acc == '0) begin
            mean_q <= '0;
            state  <= S_SUM;
          end else begin
            state <= S_DIV;
          end
        end

        S_DIV: begin
          if (div_done) begin
            mean_q <= div_quot[lmd_pkg::MEAN_W-1:0];
            state  <= S_SUM;
          end
        end

        S_SUM: begin
          if (out_free) begin
            out_valid           <= 1'b1;
            out_word.kind       <= lmd_pkg::KIND_SUMMARY;
            out_word.value      <= '0;
            out_word.row        <= '0;
            out_word.col        <= '0;
            out_word.max_count  <= count_acc;
            out_word.max_sum    <= sum_acc;
            out_word.mean_q8    <= mean_q;
            out_word.none_found <= (count_acc == '0);
            out_word.last       <= 1'b1;
            // Clear for the next frame
            row_count <= '0;
            col_count <= '0;
            sum_acc   <= '0;
            count_acc <= '0;
            flush     <= 1'b0;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign pix.ready      = (state == S_IDLE);
  assign res.valid      = out_valid;
  assign res.kind       = out_word.kind;
  assign res.value      = out_word.value;
  assign res.row        = out_word.row;
  assign res.col        = out_word.col;
  assign res.max_count  = out_word.max_count;
  assign res.max_sum    = out_word.max_sum;
  assign res.mean_q8    = out_word.mean_q8;
  assign res.none_found = out_word.none_found;
  assign res.last       = out_word.last;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    pix.valid && pix.ready |=> state != S_IDLE)
    else $error("sequencer idle right after taking a pixel");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside its wait state");

  a_empty_sum: assert property (@(posedge clk) disable iff (rst)
    count_acc == '0 |-> sum_acc == '0)
    else $error("sum accumulated without any maximum counted");

  a_summary_word: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.kind == lmd_pkg::KIND_SUMMARY |->
      res.last && (res.none_found == (res.max_count == '0)))
    else $error("summary word inconsistent");
`endif

endmodule

/* rtl/lmd_ram.sv */
`timescale 1ns / 1ps
module lmd_ram #(
  parameter int WIDTH = lmd_pkg::PIXEL_W,
  parameter int DEPTH = lmd_pkg::MAX_COLS_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/lmd_div.sv */
`timescale 1ns / 1ps
module lmd_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [lmd_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [lmd_pkg::COUNT_W-1:0]    divisor,
  output logic                           done,
  output logic [lmd_pkg::DIVIDEND_W-1:0] quotient
);

  localparam int DW = lmd_pkg::DIVIDEND_W;
  localparam int VW = lmd_pkg::COUNT_W;
  localparam int SW = $clog2(DW + 1);

  logic          busy;
  logic [SW-1:0] steps;
  logic [VW-1:0] dvs;
  logic [VW:0]   rem;
  logic [VW:0]   rem_shift;
  logic [VW:0]   rem_sub;
  logic          fits;

  // Restoring division, one quotient bit a cycle, MSB first
  always_comb begin
    rem_shift = {rem[VW-1:0], quotient[DW-1]};
    rem_sub   = rem_shift - {1'b0, dvs};
    fits      = (rem_shift >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (steps == SW'(DW - 1));
      if (start) begin
        busy     <= 1'b1;
        quotient <= dividend;
        rem      <= '0;
        dvs      <= divisor;
        steps    <= '0;
      end else if (busy) begin
        quotient <= {quotient[DW-2:0], fits};
        rem      <= fits ? rem_sub : rem_shift;
        steps    <= steps + 1'b1;
        if (steps == SW'(DW - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
module tb;

  // Run shape
  localparam int MAX_ROWS      = lmd_pkg::MAX_ROWS_DEF;
  localparam int MAX_COLS      = lmd_pkg::MAX_COLS_DEF;
  localparam int ITEMS_TOTAL   = 370;
  localparam int SETTLE_CYCLES = 4 * MAX_COLS + 40;   // last-row sweep plus mean divider
  localparam int HOLD_AT       = 280;                 // pixel count that starts the long stall
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_LIMIT  = 10;

  // Field widths
  localparam int PIXEL_W    = lmd_pkg::PIXEL_W;
  localparam int ROW_W      = lmd_pkg::ROW_W;
  localparam int COL_W      = lmd_pkg::COL_W;
  localparam int COUNT_W    = lmd_pkg::COUNT_W;
  localparam int SUM_W      = lmd_pkg::SUM_W;
  localparam int MEAN_W     = lmd_pkg::MEAN_W;
  localparam int FRAC_W     = lmd_pkg::FRAC_W;
  localparam int DIVIDEND_W = lmd_pkg::DIVIDEND_W;
  localparam int SIZE_W     = lmd_pkg::SIZE_W;
  localparam int REG_IDX_W  = lmd_pkg::REG_IDX_W;

  // One result word, field for field as it leaves the block
  typedef struct packed {
    logic                kind;
    logic [PIXEL_W-1:0]  value;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic [COUNT_W-1:0]  max_count;
    logic [SUM_W-1:0]    max_sum;
    logic [MEAN_W-1:0]   mean_q8;
    logic                none_found;
    logic                last;
  } result_t;

  // Directed script: register writes and pixels, with typed-in words where obvious
  typedef enum logic {STEP_WRITE, STEP_PIXEL} step_op_t;

  typedef struct packed {
    step_op_t            op;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [SIZE_W-1:0]   reg_val;
    logic [PIXEL_W-1:0]  pixel;
    logic [1:0]          n_typed;   // 0: take the words from the predictor
    result_t             word0;
    result_t             word1;
  } script_step_t;

  logic clk = 1'b0;
  logic rst;
  logic wr_en;
  logic [REG_IDX_W-1:0] wr_index;
  logic [SIZE_W-1:0]    wr_data;

  lmd_pixel_if  pix_if ();
  lmd_result_if res_if ();

  local_maximum_detector_core DUT (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .pix      (pix_if),
    .res      (res_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: own copy of the line stores, counters and size registers
  // ---------------------------------------------------------------------------
  logic [PIXEL_W-1:0] line_prev [MAX_COLS];   // previous row
  logic [PIXEL_W-1:0] line_cur  [MAX_COLS];   // row being filled
  int unsigned        row_pos;
  int unsigned        col_pos;
  logic [SUM_W-1:0]   acc_sum;
  logic [COUNT_W-1:0] acc_count;
  logic [SIZE_W-1:0]  rows_reg;
  logic [SIZE_W-1:0]  cols_reg;

  result_t expected_words [$];   // words still owed by the block, oldest first
  result_t step_words [$];       // words caused by the pixel just taken

  int pixels_taken   = 0;
  int frames_done    = 0;
  int reports_seen   = 0;
  int summaries_seen = 0;
  int mismatches     = 0;
  int cycle_count    = 0;
  int hold_left      = 0;
  bit hold_done      = 1'b0;

  // A size of zero behaves as one, anything past the limit as the limit
  function automatic int unsigned eff_size(logic [SIZE_W-1:0] v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Idle pattern: sender 28 / receiver 80, then swapped, then no idling at all
  function automatic int idle_phase();
    int ph;
    ph = pixels_taken * 3 / ITEMS_TOTAL;
    return (ph > 2) ? 2 : ph;
  endfunction

  function automatic int send_idle_pct();
    case (idle_phase())
      0:       return 28;
      1:       return 80;
      default: return 0;
    endcase
  endfunction

  function automatic int sink_idle_pct();
    case (idle_phase())
      0:       return 80;
      1:       return 28;
      default: return 0;
    endcase
  endfunction

  function automatic result_t report_word(logic [PIXEL_W-1:0] v, int unsigned r,
                                          int unsigned c, logic is_last);
    result_t w;
    w = '0;
    w.kind  = lmd_pkg::KIND_REPORT;
    w.value = v;
    w.row   = ROW_W'(r);
    w.col   = COL_W'(c);
    w.last  = is_last;
    return w;
  endfunction

  function automatic result_t summary_word(int unsigned cnt, int unsigned sum,
                                           int unsigned mean, logic none);
    result_t w;
    w = '0;
    w.kind       = lmd_pkg::KIND_SUMMARY;
    w.max_count  = COUNT_W'(cnt);
    w.max_sum    = SUM_W'(sum);
    w.mean_q8    = MEAN_W'(mean);
    w.none_found = none;
    w.last       = 1'b1;
    return w;
  endfunction

  // Report a pixel that strictly beats every neighbor that exists; accumulate it
  function automatic void judge_pixel(logic [PIXEL_W-1:0] v, int unsigned r, int unsigned c,
                                      bit up_ok, logic [PIXEL_W-1:0] up,
                                      bit dn_ok, logic [PIXEL_W-1:0] dn,
                                      bit lf_ok, logic [PIXEL_W-1:0] lf,
                                      bit rt_ok, logic [PIXEL_W-1:0] rt);
    if ((!up_ok || v > up) && (!dn_ok || v > dn) &&
        (!lf_ok || v > lf) && (!rt_ok || v > rt)) begin
      step_words = {step_words, report_word(v, r, c, 1'b0)};
      acc_sum   = acc_sum + SUM_W'(v);
      acc_count = acc_count + 1'b1;
    end
  endfunction

  // Advance the predictor by one taken pixel; leave its words in step_words
  function automatic void predict_pixel(logic [PIXEL_W-1:0] p);
    int unsigned        nr;
    int unsigned        nc;
    int unsigned        r;
    int unsigned        c;
    logic [DIVIDEND_W-1:0] dividend;
    logic [PIXEL_W-1:0] tmp [MAX_COLS];
    result_t            w;

    nr = eff_size(rows_reg, MAX_ROWS);
    nc = eff_size(cols_reg, MAX_COLS);
    r  = (row_pos < nr) ? row_pos : nr - 1;
    c  = (col_pos < nc) ? col_pos : nc - 1;
    step_words.delete();

    // The new pixel is the lower neighbor of line_prev[c]; line_cur[c] still
    // holds the row above that one until it is overwritten here.
    if (r > 0)
      judge_pixel(line_prev[c], r - 1, c,
                  r > 1, line_cur[c],
                  1'b1, p,
                  c > 0, (c > 0) ? line_prev[c - 1] : '0,
                  c + 1 < nc, (c + 1 < nc) ? line_prev[c + 1] : '0);
    line_cur[c] = p;

    if (c + 1 >= nc) begin
      if (r + 1 >= nr) begin
        // Final pixel: sweep the last row, then close the frame
        for (int unsigned j = 0; j < nc; j++)
          judge_pixel(line_cur[j], r, j,
                      r > 0, line_prev[j],
                      1'b0, '0,
                      j > 0, (j > 0) ? line_cur[j - 1] : '0,
                      j + 1 < nc, (j + 1 < nc) ? line_cur[j + 1] : '0);
        w = '0;
        w.kind       = lmd_pkg::KIND_SUMMARY;
        w.max_count  = acc_count;
        w.max_sum    = acc_sum;
        w.none_found = (acc_count == 0);
        if (acc_count != 0) begin
          dividend  = {acc_sum, {FRAC_W{1'b0}}};
          w.mean_q8 = MEAN_W'(dividend / DIVIDEND_W'(acc_count));
        end
        step_words = {step_words, w};
        row_pos   = 0;
        col_pos   = 0;
        acc_sum   = '0;
        acc_count = '0;
        frames_done++;
      end else begin
        tmp       = line_prev;
        line_prev = line_cur;
        line_cur  = tmp;
        row_pos   = r + 1;
        col_pos   = 0;
      end
    end else begin
      row_pos = r;
      col_pos = c + 1;
    end

    // Flag the final word of this pixel
    if (step_words.size() > 0)
      step_words[step_words.size() - 1].last = 1'b1;
  endfunction

  function automatic string word_text(result_t w);
    return $sformatf("kind=%0d value=%0d row=%0d col=%0d count=%0d sum=%0d mean=%0d none=%0d last=%0d",
                     w.kind, w.value, w.row, w.col, w.max_count, w.max_sum,
                     w.mean_q8, w.none_found, w.last);
  endfunction

  function automatic string diff_fields(result_t a, result_t b);
    string s;
    s = "";
    if (a.kind !== b.kind)             s = {s, " kind"};
    if (a.value !== b.value)           s = {s, " value"};
    if (a.row !== b.row)               s = {s, " row"};
    if (a.col !== b.col)               s = {s, " col"};
    if (a.max_count !== b.max_count)   s = {s, " max_count"};
    if (a.max_sum !== b.max_sum)       s = {s, " max_sum"};
    if (a.mean_q8 !== b.mean_q8)       s = {s, " mean_q8"};
    if (a.none_found !== b.none_found) s = {s, " none_found"};
    if (a.last !== b.last)             s = {s, " last"};
    return s;
  endfunction

  function automatic script_step_t write_step(logic [REG_IDX_W-1:0] idx,
                                              logic [SIZE_W-1:0] val);
    script_step_t s;
    s = '0;
    s.op      = STEP_WRITE;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  function automatic script_step_t pixel_step(logic [PIXEL_W-1:0] p, logic [1:0] n,
                                              result_t w0, result_t w1);
    script_step_t s;
    s = '0;
    s.op      = STEP_PIXEL;
    s.pixel   = p;
    s.n_typed = n;
    s.word0   = w0;
    s.word1   = w1;
    return s;
  endfunction

  // Pick a register value at or past the top of its range
  function automatic logic [SIZE_W-1:0] extreme_size();
    case ($urandom_range(0, 3))
      0:       return SIZE_W'(32);
      1:       return SIZE_W'(33);
      2:       return SIZE_W'(63);
      default: return SIZE_W'($urandom_range(34, 62));
    endcase
  endfunction

  // Pixel content styles: full range, tie-heavy, extremes only, plateau with spikes
  function automatic logic [PIXEL_W-1:0] random_pixel(int style);
    case (style)
      0:       return PIXEL_W'($urandom_range(0, 255));
      1:       return PIXEL_W'($urandom_range(0, 3));
      2:       return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      default: return ($urandom_range(0, 9) == 0) ? PIXEL_W'($urandom_range(0, 255)) : 8'd100;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus side
  // ---------------------------------------------------------------------------

  // Offer one pixel word with random gaps; on acceptance, queue what it owes.
  // valid stays high on return so a following word goes out without a bubble.
  task automatic drive_pixel(input logic [PIXEL_W-1:0] p, input logic [1:0] n_typed,
                             input result_t w0, input result_t w1);
    while ($urandom_range(0, 99) < send_idle_pct()) begin
      pix_if.valid <= 1'b0;
      @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.pixel <= p;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    pixels_taken++;
    predict_pixel(p);
    if (n_typed == 0) begin
      expected_words = {expected_words, step_words};
    end else begin
      expected_words = {expected_words, w0};
      if (n_typed > 1) expected_words = {expected_words, w1};
    end
  endtask

  // Drop valid, wait for every owed word, then let the block finish any tail work
  task automatic settle_idle();
    pix_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; wr_en then drops again before the task returns
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    if (idx == lmd_pkg::REG_NUM_ROWS) rows_reg = val;
    else                              cols_reg = val;
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: check each accepted word, then pick next ready
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      got = {res_if.kind, res_if.value, res_if.row, res_if.col, res_if.max_count,
             res_if.max_sum, res_if.mean_q8, res_if.none_found, res_if.last};
      if (got.kind === lmd_pkg::KIND_SUMMARY) summaries_seen++;
      else                                    reports_seen++;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("ERROR: unexpected result word: %s", word_text(got));
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("ERROR: result word differs in%s", diff_fields(want, got));
            $display("  expected: %s", word_text(want));
            $display("  actual:   %s", word_text(got));
          end
        end
      end
    end

    // Long back-pressure stretch once the run is well along; the sender keeps
    // offering pixels meanwhile, so the block backs up and stalls its input.
    if (!hold_done && pixels_taken >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct());
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ERROR: timeout after %0d cycles, %0d words still owed",
             cycle_count, expected_words.size());
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    script_step_t  script [$];
    script_step_t  s;
    logic [SIZE_W-1:0] rv;
    logic [SIZE_W-1:0] cv;
    int            frame_idx;
    int            style;
    int unsigned   n_pix;
    bit            new_size;

    // Hold every input at a known value from time zero
    rst          = 1'b1;
    wr_en        = 1'b0;
    wr_index     = '0;
    wr_data      = '0;
    pix_if.valid = 1'b0;
    pix_if.pixel = '0;
    res_if.ready = 1'b0;

    // Predictor matches the block after reset
    foreach (line_prev[i]) line_prev[i] = '0;
    foreach (line_cur[i])  line_cur[i]  = '0;
    row_pos   = 0;
    col_pos   = 0;
    acc_sum   = '0;
    acc_count = '0;
    rows_reg  = lmd_pkg::NUM_ROWS_RST;
    cols_reg  = lmd_pkg::NUM_COLS_RST;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Zero sizes act as 1x1: a lone pixel has no neighbors, so
    // it is always a maximum, even at value zero.
    script = {script, write_step(lmd_pkg::REG_NUM_ROWS, 6'd0)};
    script = {script, write_step(lmd_pkg::REG_NUM_COLS, 6'd0)};
    script = {script, pixel_step(8'd200, 2'd2, report_word(8'd200, 0, 0, 1'b0),
                                 summary_word(1, 200, 200 * 256, 1'b0))};
    script = {script, pixel_step(8'd0, 2'd2, report_word(8'd0, 0, 0, 1'b0),
                                 summary_word(1, 0, 0, 1'b0))};
    script = {script, pixel_step(8'd255, 2'd2, report_word(8'd255, 0, 0, 1'b0),
                                 summary_word(1, 255, 255 * 256, 1'b0))};
    // A tie in a 1x2 frame: nothing qualifies, summary flags none found
    script = {script, write_step(lmd_pkg::REG_NUM_COLS, 6'd2)};
    script = {script, pixel_step(8'd7, 2'd0, '0, '0)};
    script = {script, pixel_step(8'd7, 2'd1, summary_word(0, 0, 0, 1'b1), '0)};
    // 3x3 checkerboard of extremes: corners and center win
    script = {script, write_step(lmd_pkg::REG_NUM_ROWS, 6'd3)};
    script = {script, write_step(lmd_pkg::REG_NUM_COLS, 6'd3)};
    for (int i = 0; i < 9; i++)
      script = {script, pixel_step((i % 2 == 0) ? 8'd255 : 8'd0, 2'd0, '0, '0)};
    // Single row: only left and right neighbors count
    script = {script, write_step(lmd_pkg::REG_NUM_ROWS, 6'd1)};
    script = {script, write_step(lmd_pkg::REG_NUM_COLS, 6'd4)};
    script = {script, pixel_step(8'd9, 2'd0, '0, '0)};
    script = {script, pixel_step(8'd3, 2'd0, '0, '0)};
    script = {script, pixel_step(8'd3, 2'd0, '0, '0)};
    script = {script, pixel_step(8'd8, 2'd0, '0, '0)};
    // Single column: only up and down neighbors count, with a vertical tie
    script = {script, write_step(lmd_pkg::REG_NUM_ROWS, 6'd4)};
    script = {script, write_step(lmd_pkg::REG_NUM_COLS, 6'd1)};
    script = {script, pixel_step(8'd10, 2'd0, '0, '0)};
    script = {script, pixel_step(8'd20, 2'd0, '0, '0)};
    script = {script, pixel_step(8'd20, 2'd0, '0, '0)};
    script = {script, pixel_step(8'd30, 2'd0, '0, '0)};

    foreach (script[i]) begin
      s = script[i];
      if (s.op == STEP_WRITE) begin
        settle_idle();
        write_reg(s.reg_idx, s.reg_val);
      end else begin
        drive_pixel(s.pixel, s.n_typed, s.word0, s.word1);
      end
    end

    // Random part: whole frames only, so the line stores are never read
    // before they are written. Start with frames at the size limit in one dimension, then mostly
    // small frames; keep the size for some frames so they run back to back.
    frame_idx = 0;
    while (pixels_taken < ITEMS_TOTAL) begin
      new_size = (frame_idx < 3) || ($urandom_range(0, 2) != 0);
      if (new_size) begin
        case (frame_idx)
          0: begin rv = 6'd32; cv = 6'd1;  end
          1: begin rv = 6'd1;  cv = 6'd63; end
          2: begin rv = 6'd63; cv = 6'd2;  end
          default: begin
            case ($urandom_range(0, 9))
              0: begin
                rv = extreme_size();
                cv = SIZE_W'($urandom_range(0, 2));
              end
              1: begin
                rv = SIZE_W'($urandom_range(0, 2));
                cv = extreme_size();
              end
              default: begin
                rv = SIZE_W'($urandom_range(0, 7));
                cv = SIZE_W'($urandom_range(0, 7));
              end
            endcase
          end
        endcase
        settle_idle();
        write_reg(lmd_pkg::REG_NUM_ROWS, rv);
        write_reg(lmd_pkg::REG_NUM_COLS, cv);
      end
      style = $urandom_range(0, 3);
      n_pix = eff_size(rows_reg, MAX_ROWS) * eff_size(cols_reg, MAX_COLS);
      repeat (n_pix) drive_pixel(random_pixel(style), 2'd0, '0, '0);
      frame_idx++;
    end

    // Drain and watch a little longer for stray words
    settle_idle();

    $display("Run covered %0d pixels in %0d frames, sizes 1x1 up to 32 rows or columns",
             pixels_taken, frames_done);
    $display("Checked %0d maximum reports and %0d frame summaries, %0d mismatching words",
             reports_seen, summaries_seen, mismatches);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
